[rtl/core/bur_pkg.sv]
// Package for the baseline UVW rotation block: payload structs, fixed-point
// widths, register indexes and the trig clamp helper. No dependencies.
package bur_pkg;

  localparam int COORD_BITS     = 32;
  localparam int TRIG_BITS      = 32;
  localparam int TRIG_FRAC_BITS = 30;
  localparam int WAVE_BITS      = 32;
  localparam int WAVE_FRAC_BITS = 24;
  localparam int OUT_FRAC_BITS  = 10;
  localparam int OUTW_BITS      = 40;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 32;

  // clamped trig values span -1.0 .. +1.0 inclusive
  localparam int TW = TRIG_FRAC_BITS + 2;
  // trig times coordinate
  localparam int PW = TW + COORD_BITS;
  // wavelength in millimetres (x1000 needs 10 more bits)
  localparam int DW = WAVE_BITS + 10;
  localparam int MM_PER_M = 1000;

  localparam logic signed [TRIG_BITS-1:0] TRIG_ONE = TRIG_BITS'(1) << TRIG_FRAC_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SIN_DEC = 1'b0,
    CFG_COS_DEC = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_diff;
    logic signed [COORD_BITS-1:0] y_diff;
    logic signed [COORD_BITS-1:0] z_diff;
    logic signed [TRIG_BITS-1:0]  sin_hour_angle;
    logic signed [TRIG_BITS-1:0]  cos_hour_angle;
    logic [WAVE_BITS-1:0]         wave_len;
  } in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] u_mm;
    logic signed [COORD_BITS-1:0] v_mm;
    logic signed [COORD_BITS-1:0] w_mm;
    logic signed [OUTW_BITS-1:0]  u_waves;
    logic signed [OUTW_BITS-1:0]  v_waves;
    logic signed [OUTW_BITS-1:0]  w_waves;
  } out_t;

  // item after the front end: trig clamped to +-1.0
  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_diff;
    logic signed [COORD_BITS-1:0] y_diff;
    logic signed [COORD_BITS-1:0] z_diff;
    logic signed [TW-1:0]         sin_ha;
    logic signed [TW-1:0]         cos_ha;
    logic [WAVE_BITS-1:0]         wave_len;
  } item_t;

  // rotated coordinates on their way to the divider
  typedef struct packed {
    logic signed [COORD_BITS-1:0] u_mm;
    logic signed [COORD_BITS-1:0] v_mm;
    logic signed [COORD_BITS-1:0] w_mm;
    logic [WAVE_BITS-1:0]         wave_len;
  } rot_t;

  function automatic logic signed [TW-1:0] clamp_trig(input logic [TRIG_BITS-1:0] raw);
    logic signed [TRIG_BITS-1:0] t;
    logic signed [TRIG_BITS-1:0] r;
    t = raw;
    if (t > TRIG_ONE) begin
      r = TRIG_ONE;
    end else if (t < -TRIG_ONE) begin
      r = -TRIG_ONE;
    end else begin
      r = t;
    end
    return r[TW-1:0];
  endfunction

endpackage

[rtl/core/bur_front.sv]
// Front end: takes items on the start/busy handshake, clamps the hour-angle
// trig values and registers the item. Depends on bur_pkg.
module bur_front import bur_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  accept_i,
  input  in_t   in_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q, item_d;

  always_comb begin
    item_d.x_diff   = in_i.x_diff;
    item_d.y_diff   = in_i.y_diff;
    item_d.z_diff   = in_i.z_diff;
    item_d.sin_ha   = clamp_trig(in_i.sin_hour_angle);
    item_d.cos_ha   = clamp_trig(in_i.cos_hour_angle);
    item_d.wave_len = in_i.wave_len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/core/bur_queue.sv]
// Two-entry queue between front end and back end; the head is popped
// whenever present. Depends on bur_pkg.
module bur_queue import bur_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o,
  output logic  full_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop   = (cnt_q != 2'd0);
  assign cnt_d = cnt_q + 2'(push_i) - 2'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop)    rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign valid_o = pop;
  assign item_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == 2'd2);

endmodule

[rtl/core/bur_rotate.sv]
// Three-stage XYZ to UVW rotation: trig products, coordinate products, then
// rounded sums saturated to millimetres. Depends on bur_pkg.
module bur_rotate import bur_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  item_t                item_i,
  input  logic [TRIG_BITS-1:0] sin_dec_i,
  input  logic [TRIG_BITS-1:0] cos_dec_i,
  output logic                 valid_o,
  output rot_t                 rot_o
);

  localparam int SW = PW + 2;
  localparam logic signed [2*TW-1:0] RND_T = (2*TW)'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [SW-1:0]   RND_S = SW'(1) << (TRIG_FRAC_BITS - 1);

  // coefficient order: u(x,y), v(x,y,z), w(x,y,z)
  logic [2:0] vld_q;

  logic signed [TW-1:0] sd, cd;
  logic signed [TW-1:0] m_sd_ch, m_sd_sh, m_cd_ch, m_cd_sh;

  logic signed [TW-1:0]         t_q [8];
  logic signed [COORD_BITS-1:0] c1_q [3];
  logic [WAVE_BITS-1:0]         lam1_q;

  logic signed [PW-1:0]         p_q [8];
  logic [WAVE_BITS-1:0]         lam2_q;

  logic signed [SW-1:0]         su, sv, sw;
  rot_t                         rot_q, rot_d;

  function automatic logic signed [TW-1:0] trig_mul(input logic signed [TW-1:0] a,
                                                    input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = a * b + RND_T;
    return p[TRIG_FRAC_BITS+TW-1:TRIG_FRAC_BITS];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] round_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0]         r;
    logic [SW-TRIG_FRAC_BITS-1:0] sh;
    logic [COORD_BITS-1:0]        res;
    r  = s + RND_S;
    sh = r[SW-1:TRIG_FRAC_BITS];
    // saturate when the top bits are not a sign extension
    if (sh[SW-TRIG_FRAC_BITS-1:COORD_BITS-1] == '0 ||
        sh[SW-TRIG_FRAC_BITS-1:COORD_BITS-1] == '1) begin
      res = sh[COORD_BITS-1:0];
    end else if (sh[SW-TRIG_FRAC_BITS-1]) begin
      res = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return res;
  endfunction

  assign sd      = clamp_trig(sin_dec_i);
  assign cd      = clamp_trig(cos_dec_i);
  assign m_sd_ch = trig_mul(sd, item_i.cos_ha);
  assign m_sd_sh = trig_mul(sd, item_i.sin_ha);
  assign m_cd_ch = trig_mul(cd, item_i.cos_ha);
  assign m_cd_sh = trig_mul(cd, item_i.sin_ha);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    t_q[0] <= item_i.sin_ha;
    t_q[1] <= item_i.cos_ha;
    t_q[2] <= -m_sd_ch;
    t_q[3] <= m_sd_sh;
    t_q[4] <= cd;
    t_q[5] <= m_cd_ch;
    t_q[6] <= -m_cd_sh;
    t_q[7] <= sd;
    c1_q[0] <= item_i.x_diff;
    c1_q[1] <= item_i.y_diff;
    c1_q[2] <= item_i.z_diff;
    lam1_q  <= item_i.wave_len;

    p_q[0] <= t_q[0] * c1_q[0];
    p_q[1] <= t_q[1] * c1_q[1];
    p_q[2] <= t_q[2] * c1_q[0];
    p_q[3] <= t_q[3] * c1_q[1];
    p_q[4] <= t_q[4] * c1_q[2];
    p_q[5] <= t_q[5] * c1_q[0];
    p_q[6] <= t_q[6] * c1_q[1];
    p_q[7] <= t_q[7] * c1_q[2];
    lam2_q <= lam1_q;

    rot_q <= rot_d;
  end

  always_comb begin
    su = SW'(p_q[0]) + SW'(p_q[1]);
    sv = SW'(p_q[2]) + SW'(p_q[3]) + SW'(p_q[4]);
    sw = SW'(p_q[5]) + SW'(p_q[6]) + SW'(p_q[7]);
    rot_d.u_mm     = round_sat(su);
    rot_d.v_mm     = round_sat(sv);
    rot_d.w_mm     = round_sat(sw);
    rot_d.wave_len = lam2_q;
  end

  assign valid_o = vld_q[2];
  assign rot_o   = rot_q;

endmodule

[rtl/core/bur_divide.sv]
// Pipelined restoring divider: turns u, v, w millimetres into wavelengths,
// one quotient bit per stage, rounded half away from zero and saturated.
// Depends on bur_pkg.
module bur_divide import bur_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  rot_t rot_i,
  output logic valid_o,
  output out_t out_o
);

  localparam int MW   = COORD_BITS;
  localparam int K1   = WAVE_FRAC_BITS + OUT_FRAC_BITS + 1;
  localparam int NW   = MW + K1;
  localparam int QB   = OUTW_BITS + 1;
  localparam int NUMW = (NW > QB) ? NW : QB + 1;
  localparam int HW   = NUMW - QB;
  localparam int CW   = (HW > DW) ? HW : DW;
  localparam logic [QB-1:0] HALF = QB'(1) << (OUTW_BITS - 1);

  // setup, first step register, QB steps and the output register
  logic [QB+2:0]              vld_q;
  logic [DW-1:0]              d0_q;
  logic [MW-1:0]              mag0_q [3];
  logic                       neg0_q [3];
  logic signed [MW-1:0]       mm0_q  [3];

  logic [DW-1:0]              d_q    [QB+1];
  logic [DW-1:0]              rem_q  [3][QB+1];
  logic [QB-1:0]              quo_q  [3][QB+1];
  logic [QB-1:0]              low_q  [3][QB+1];
  logic                       neg_q  [3][QB+1];
  logic                       sat_q  [3][QB+1];
  logic                       zero_q [3][QB+1];
  logic signed [MW-1:0]       mm_q   [3][QB+1];

  logic signed [OUTW_BITS-1:0] wv [3];
  out_t                        out_q, out_d;

  function automatic logic signed [OUTW_BITS-1:0] finish(input logic [QB-1:0] q,
                                                         input logic neg, input logic sat,
                                                         input logic zero);
    logic [QB:0]   s;
    logic [QB-1:0] rnd;
    logic [QB-1:0] lim;
    s   = {1'b0, q} + (QB+1)'(1);
    rnd = s[QB:1];
    lim = neg ? HALF : HALF - QB'(1);
    if (sat || rnd > lim) rnd = lim;
    if (zero) rnd = '0;
    return neg ? -OUTW_BITS'(rnd) : OUTW_BITS'(rnd);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QB+1:0], valid_i};
    end
  end

  // setup: divisor in millimetres, magnitudes and signs
  always_ff @(posedge clk_i) begin
    d0_q <= DW'(rot_i.wave_len) * DW'(MM_PER_M);
    mm0_q[0] <= rot_i.u_mm;
    mm0_q[1] <= rot_i.v_mm;
    mm0_q[2] <= rot_i.w_mm;
    d_q[0]   <= d0_q;
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [MW-1:0] mm_in;
    logic [NUMW-1:0]      num;
    logic [HW-1:0]        hi;

    assign mm_in = (l == 0) ? rot_i.u_mm : (l == 1) ? rot_i.v_mm : rot_i.w_mm;
    assign num   = NUMW'({mag0_q[l], {K1{1'b0}}});
    assign hi    = num[NUMW-1:QB];

    always_ff @(posedge clk_i) begin
      neg0_q[l] <= mm_in[MW-1];
      mag0_q[l] <= mm_in[MW-1] ? (~mm_in + MW'(1)) : mm_in;

      // quotient at or above 2^QB saturates, also the zero divisor
      sat_q[l][0]  <= (CW'(hi) >= CW'(d0_q));
      zero_q[l][0] <= (mag0_q[l] == '0);
      neg_q[l][0]  <= neg0_q[l];
      rem_q[l][0]  <= DW'(hi);
      quo_q[l][0]  <= '0;
      low_q[l][0]  <= num[QB-1:0];
      mm_q[l][0]   <= mm0_q[l];
    end

    for (genvar s = 0; s < QB; s++) begin : g_step
      logic [DW:0] rs;
      logic        ge;
      assign rs = {rem_q[l][s], low_q[l][s][QB-1]};
      assign ge = (rs >= {1'b0, d_q[s]});
      always_ff @(posedge clk_i) begin
        rem_q[l][s+1]  <= ge ? DW'(rs - {1'b0, d_q[s]}) : rs[DW-1:0];
        quo_q[l][s+1]  <= {quo_q[l][s][QB-2:0], ge};
        low_q[l][s+1]  <= {low_q[l][s][QB-2:0], 1'b0};
        neg_q[l][s+1]  <= neg_q[l][s];
        sat_q[l][s+1]  <= sat_q[l][s];
        zero_q[l][s+1] <= zero_q[l][s];
        mm_q[l][s+1]   <= mm_q[l][s];
      end
    end

    assign wv[l] = finish(quo_q[l][QB], neg_q[l][QB], sat_q[l][QB], zero_q[l][QB]);
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    always_ff @(posedge clk_i) begin
      d_q[s+1] <= d_q[s];
    end
  end

  always_comb begin
    out_d.u_mm    = mm_q[0][QB];
    out_d.v_mm    = mm_q[1][QB];
    out_d.w_mm    = mm_q[2][QB];
    out_d.u_waves = wv[0];
    out_d.v_waves = wv[1];
    out_d.w_waves = wv[2];
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign valid_o = vld_q[QB+2];
  assign out_o   = out_q;

endmodule

[rtl/core/baseline_uvw_rotation.sv]
// Baseline XYZ to UVW rotation with conversion to wavelengths.
// Items pass the front register, queue, rotation and divider in turn; one item
// per cycle is taken while busy is low, set by the fully pipelined rotation and
// the one-bit-per-stage divider. Results cannot be stalled by the receiver.
// Reset clears all valid state; declination registers reset to sine 0 and
// cosine 1.0. Depends on bur_pkg, bur_front, bur_queue, bur_rotate, bur_divide.
module baseline_uvw_rotation import bur_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  in_t                      in_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output logic                     out_valid_o,
  output out_t                     out_o
);

  logic [TRIG_BITS-1:0] sin_dec_q, cos_dec_q;
  logic                 fr_valid, q_valid, q_full, rot_valid;
  item_t                fr_item, q_item;
  rot_t                 rot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_dec_q <= '0;
      cos_dec_q <= TRIG_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SIN_DEC: sin_dec_q <= cfg_data_i[TRIG_BITS-1:0];
        CFG_COS_DEC: cos_dec_q <= cfg_data_i[TRIG_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign busy = q_full;

  bur_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (start && !busy),
    .in_i     (in_i),
    .valid_o  (fr_valid),
    .item_o   (fr_item)
  );

  bur_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .item_i  (fr_item),
    .valid_o (q_valid),
    .item_o  (q_item),
    .full_o  (q_full)
  );

  bur_rotate u_rotate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (q_valid),
    .item_i    (q_item),
    .sin_dec_i (sin_dec_q),
    .cos_dec_i (cos_dec_q),
    .valid_o   (rot_valid),
    .rot_o     (rot)
  );

  bur_divide u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .rot_i   (rot),
    .valid_o (out_valid_o),
    .out_o   (out_o)
  );

endmodule

[tb/baseline_uvw_rotation_check.sv]
// Checker for baseline_uvw_rotation: watches the item, register and result
// ports, predicts each result in fixed point and compares it. Depends on bur_pkg.
`timescale 1ns / 100ps
module baseline_uvw_rotation_check import bur_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic                     busy,
  input  in_t                      in_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                     out_valid_o,
  input  out_t                     out_o,
  output int                       errors_o,
  output int                       pending_o,
  output int                       results_o
);

  localparam logic signed [31:0] Q_ONE = 32'sd1 <<< TRIG_FRAC_BITS;

  logic signed [31:0] sin_dec_q, cos_dec_q;
  out_t uvw_expected[$];

  function automatic logic signed [31:0] limit_unit(input logic [31:0] raw);
    logic signed [31:0] t;
    t = raw;
    if (t > Q_ONE) return Q_ONE;
    if (t < -Q_ONE) return -Q_ONE;
    return t;
  endfunction

  function automatic logic signed [31:0] trig_product(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a;
    p = p * b + (64'sd1 <<< (TRIG_FRAC_BITS - 1));
    p = p >>> TRIG_FRAC_BITS;
    return p[31:0];
  endfunction

  // exact three-term dot product, rounded ties up, saturated to the coord width
  function automatic logic signed [31:0] rotate_mm(input logic signed [31:0] t0, t1, t2,
                                                   input logic signed [31:0] c0, c1, c2);
    logic signed [95:0] s, a, b;
    s = '0;
    a = t0; b = c0; s = s + a * b;
    a = t1; b = c1; s = s + a * b;
    a = t2; b = c2; s = s + a * b;
    s = (s + (96'sd1 <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    if (s > 96'sd2147483647) return 32'h7fffffff;
    if (s < -96'sd2147483648) return 32'h80000000;
    return s[31:0];
  endfunction

  function automatic logic signed [OUTW_BITS-1:0] mm_to_waves(input logic signed [31:0] mm,
                                                              input logic [31:0] lam);
    logic [127:0] mag, q, d, lim, half;
    logic signed [63:0] m64;
    lim  = 128'd1 << (OUTW_BITS + 1);
    half = 128'd1 << (OUTW_BITS - 1);
    m64 = mm;
    if (mm == 0) return '0;
    mag = (mm < 0) ? 128'(-m64) : 128'(m64);
    if (lam == 0) begin
      q = half;
    end else begin
      d = 128'(lam) * 128'd1000;
      q = (mag << (WAVE_FRAC_BITS + OUT_FRAC_BITS + 1)) / d;
      if (q > lim) q = lim;
      q = (q + 1) >> 1;
    end
    if (mm < 0) begin
      if (q > half) q = half;
      return -$signed(q[OUTW_BITS:0]);
    end
    if (q > half - 1) q = half - 1;
    return q[OUTW_BITS-1:0];
  endfunction

  function automatic out_t predict_uvw(input in_t it);
    out_t r;
    logic signed [31:0] sh, ch, sd, cd;
    sh = limit_unit(it.sin_hour_angle);
    ch = limit_unit(it.cos_hour_angle);
    sd = limit_unit(sin_dec_q);
    cd = limit_unit(cos_dec_q);
    r.u_mm = rotate_mm(sh, ch, 32'sd0, it.x_diff, it.y_diff, it.z_diff);
    r.v_mm = rotate_mm(-trig_product(sd, ch), trig_product(sd, sh), cd,
                       it.x_diff, it.y_diff, it.z_diff);
    r.w_mm = rotate_mm(trig_product(cd, ch), -trig_product(cd, sh), sd,
                       it.x_diff, it.y_diff, it.z_diff);
    r.u_waves = mm_to_waves(r.u_mm, it.wave_len);
    r.v_waves = mm_to_waves(r.v_mm, it.wave_len);
    r.w_waves = mm_to_waves(r.w_mm, it.wave_len);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors_o++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    if (!rst_ni) begin
      sin_dec_q <= '0;
      cos_dec_q <= Q_ONE;
      uvw_expected.delete();
      errors_o  <= 0;
      results_o <= 0;
    end else begin
      if (start && !busy) uvw_expected.push_back(predict_uvw(in_i));
      if (out_valid_o) begin
        results_o++;
        if (uvw_expected.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result: expected none, got %h", $time, out_o);
        end else begin
          e = uvw_expected.pop_front();
          compare_field("u_mm", 64'(e.u_mm), 64'(out_o.u_mm));
          compare_field("v_mm", 64'(e.v_mm), 64'(out_o.v_mm));
          compare_field("w_mm", 64'(e.w_mm), 64'(out_o.w_mm));
          compare_field("u_waves", 64'(e.u_waves), 64'(out_o.u_waves));
          compare_field("v_waves", 64'(e.v_waves), 64'(out_o.v_waves));
          compare_field("w_waves", 64'(e.w_waves), 64'(out_o.w_waves));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_e'(cfg_idx_i) == CFG_SIN_DEC) sin_dec_q <= cfg_data_i;
        if (cfg_idx_e'(cfg_idx_i) == CFG_COS_DEC) cos_dec_q <= cfg_data_i;
      end
    end
  end

  assign pending_o = uvw_expected.size();

endmodule

[tb/baseline_uvw_rotation_tb.sv]
// Top of the baseline_uvw_rotation testbench: clock, reset, item and register
// stimulus and the verdict. Depends on bur_pkg and baseline_uvw_rotation_check.
`timescale 1ns / 100ps
module baseline_uvw_rotation_tb import bur_pkg::*; ();

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 180;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_r = '0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic out_valid;
  out_t out_w;
  int   errors, pending, results;
  int   items_sent = 0;
  int   cycles = 0;

  always #5 clk_i = ~clk_i;

  baseline_uvw_rotation dut (
    .clk_i, .rst_ni, .start, .busy, .in_i(in_r),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid), .out_o(out_w)
  );

  baseline_uvw_rotation_check check (
    .clk_i, .rst_ni, .start, .busy, .in_i(in_r),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid), .out_o(out_w),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return 32'($signed($urandom_range(2000)) - 1000);
      1: return 32'($signed($urandom_range(200000000)) - 100000000);
      default: return $urandom;
    endcase
  endfunction

  // mostly legal trig, now and then any bit pattern to hit the clamp
  function automatic logic [31:0] rand_trig();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($signed($urandom_range(32'h80000000)) - 32'sh40000000);
  endfunction

  function automatic logic [31:0] rand_wave();
    case ($urandom_range(3))
      0: return $urandom_range(32'h0100_0000, 32'h0001_0000);
      1: return $urandom_range(255) + 1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t rand_item();
    in_t it;
    it.x_diff = rand_coord();
    it.y_diff = rand_coord();
    it.z_diff = rand_coord();
    it.sin_hour_angle = rand_trig();
    it.cos_hour_angle = rand_trig();
    it.wave_len = rand_wave();
    return it;
  endfunction

  task automatic send_item(input in_t it, input int idle_pct);
    in_r  <= it;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // drop start, let every transfer come back, then write both registers
  task automatic set_declination(input logic [31:0] sin_v, input logic [31:0] cos_v);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= CFG_SIN_DEC; cfg_data <= sin_v;
    @(posedge clk_i);
    cfg_idx <= CFG_COS_DEC; cfg_data <= cos_v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_items();
    in_t it;
    logic [31:0] xs[6] = '{32'h7fffffff, 32'h80000000, 32'd0, 32'd1, 32'hffffffff, 32'd123456};
    logic [31:0] ts[5] = '{32'h40000000, 32'hc0000000, 32'h7fffffff, 32'h80000000, 32'd0};
    logic [31:0] ws[5] = '{32'd1, 32'hffffffff, 32'd0, 32'h01000000, 32'h00000100};
    for (int k = 0; k < 22; k++) begin
      it.x_diff = xs[k % 6];
      it.y_diff = xs[(k + 1) % 6];
      it.z_diff = xs[(k + 3) % 6];
      it.sin_hour_angle = ts[k % 5];
      it.cos_hour_angle = ts[(k + 2) % 5];
      it.wave_len = ws[(k / 2) % 5];
      send_item(it, 0);
    end
  endtask

  initial begin
    logic [31:0] sin_set[6] = '{32'h0, 32'h40000000, 32'hc0000000, 32'h7fffffff,
                                32'h2d413ccd, 32'h0};
    logic [31:0] cos_set[6] = '{32'h40000000, 32'h0, 32'h0, 32'h80000000,
                                32'h2d413ccd, 32'h0};
    int idle_set[3] = '{0, 60, 28};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_declination(sin_set[0], cos_set[0]);
    directed_items();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) set_declination(rand_trig(), rand_trig());
      else set_declination(sin_set[ph], cos_set[ph]);
      if (ph == 3) directed_items();
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_item(), idle_set[ph % 3]);
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Ran %0d baselines through 7 declination settings, %0d results checked.",
             items_sent, results);
    $display("Covered saturation, trig clamping, zero wavelength and sender gaps.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
